FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is high
`define TFN_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tfn assertion failed");

// clocked assertion, also checked across reset
`define TFN_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("tfn assertion failed");

`endif

FILE: design/tfn_pkg.sv
// Shared constants and types of the triangle face normal block.
// No dependencies.
package tfn_pkg;
   localparam int MINLEN_WIDTH = 52;
   localparam int NORM_WIDTH   = 32;
   localparam int RSP_W        = 3 * NORM_WIDTH;

   typedef struct packed {
      logic last;
      logic has_normal;
   } tag_type;
endpackage

FILE: design/triangle_face_normal_top.sv
// Triangle unit face normal: edges, cross product, length, normalization.
// Depends on tfn_pkg, tfn_sqrt_pipe and tfn_div_pipe.
//
//   channel | direction | tdata                                 | side bits
//   req_    | in        | v0_x v0_y v0_z v1_x .. v2_z, low first | tlast = last_face
//   rsp_    | out       | normal_x normal_y normal_z            | tuser = has_normal,
//           |           |                                       | tlast = last_out
//   csr_    | in        | min_length                            | -
//
// The pipe has seven front stages, one per root bit of the square root, one per quotient
// bit of the divider, and the output register. One triangle enters per cycle while the
// pipe advances. The whole pipe advances when the output register is empty or taken; a
// stall freezes every stage. Reset clears the valid bits and sets min_length to 1.
module triangle_face_normal_top import tfn_pkg::*; #(
   parameter int COORD_WIDTH      = 24,
   parameter int NORMAL_FRAC_BITS = 30
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z from bit 0 up
   input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]    req_tdata,
   input  logic                                  req_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // normal_x, normal_y, normal_z from bit 0 up
   output logic [RSP_W-1:0]                      rsp_tdata,
   // has_normal
   output logic                                  rsp_tuser,
   output logic                                  rsp_tlast,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [MINLEN_WIDTH-1:0]               csr_data
);
   localparam int CW   = COORD_WIDTH;
   localparam int EW   = CW + 1;
   localparam int PW   = 2 * EW;
   localparam int NW   = PW + 1;
   localparam int MW   = NW - 1;
   localparam int LO   = MW / 2;
   localparam int HI   = MW - LO;
   localparam int SW   = 2 * MW;
   localparam int RW   = MW + 1;
   localparam int QW   = NORMAL_FRAC_BITS + 1;
   localparam int SBW  = 3 * MW + 4;
   localparam int CMPW = (RW > MINLEN_WIDTH) ? RW : MINLEN_WIDTH;

   logic adv;
   logic [MINLEN_WIDTH-1:0] min_length_ff;
   logic [6:0] vld_ff;

   logic signed [CW-1:0] v [9];
   logic signed [EW-1:0] e1_ff [3];
   logic signed [EW-1:0] e2_ff [3];
   logic signed [PW-1:0] p_ff [6];
   logic signed [NW-1:0] n_ff [3];
   logic signed [NW-1:0] nabs [3];
   logic [MW-1:0]        mag4_ff [3];
   logic [MW-1:0]        mag5_ff [3];
   logic [MW-1:0]        mag6_ff [3];
   logic [2:0]           neg4_ff, neg5_ff, neg6_ff;
   logic [2*HI-1:0]      hh_ff [3];
   logic [HI+LO-1:0]     hl_ff [3];
   logic [2*LO-1:0]      ll_ff [3];
   logic [SW-1:0]        sq_ff [3];
   logic [2*RW-1:0]      ss_ff;
   logic [SBW-1:0]       sb7_ff;
   logic                 last1_ff, last2_ff, last3_ff, last4_ff, last5_ff, last6_ff;

   logic                 sq_vld;
   logic [RW-1:0]        root;
   logic [SBW-1:0]       sq_sb;
   tag_type              tag_in;
   logic [2:0][RW-1:0]   div_mag;

   logic                 div_vld;
   tag_type              div_tag;
   logic [2:0][QW-1:0]   div_q;
   logic [2:0]           div_neg;

   logic                 out_vld_ff;
   logic [RSP_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                 rsp_user_ff, rsp_last_ff;

   assign adv        = !out_vld_ff || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= MINLEN_WIDTH'(1);
      end else if (csr_valid) begin
         min_length_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[5:0], req_tvalid};
      end
   end

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         v[k] = req_tdata[k*CW +: CW];
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         nabs[k] = n_ff[k][NW-1] ? -n_ff[k] : n_ff[k];
      end
   end

   // front stages: edges, products, cross terms, magnitude, partial squares, squares, sum
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            e1_ff[k] <= EW'(v[3+k]) - EW'(v[k]);
            e2_ff[k] <= EW'(v[6+k]) - EW'(v[k]);
         end
         last1_ff <= req_tlast;

         p_ff[0]  <= e1_ff[1] * e2_ff[2];
         p_ff[1]  <= e1_ff[2] * e2_ff[1];
         p_ff[2]  <= e1_ff[2] * e2_ff[0];
         p_ff[3]  <= e1_ff[0] * e2_ff[2];
         p_ff[4]  <= e1_ff[0] * e2_ff[1];
         p_ff[5]  <= e1_ff[1] * e2_ff[0];
         last2_ff <= last1_ff;

         for (int k = 0; k < 3; k++) begin
            n_ff[k] <= NW'(p_ff[2*k]) - NW'(p_ff[2*k+1]);
         end
         last3_ff <= last2_ff;

         for (int k = 0; k < 3; k++) begin
            mag4_ff[k] <= nabs[k][MW-1:0];
            neg4_ff[k] <= n_ff[k][NW-1];
         end
         last4_ff <= last3_ff;

         for (int k = 0; k < 3; k++) begin
            hh_ff[k] <= mag4_ff[k][MW-1:LO] * mag4_ff[k][MW-1:LO];
            hl_ff[k] <= mag4_ff[k][MW-1:LO] * mag4_ff[k][LO-1:0];
            ll_ff[k] <= mag4_ff[k][LO-1:0] * mag4_ff[k][LO-1:0];
         end
         mag5_ff  <= mag4_ff;
         neg5_ff  <= neg4_ff;
         last5_ff <= last4_ff;

         for (int k = 0; k < 3; k++) begin
            sq_ff[k] <= (SW'(hh_ff[k]) << (2*LO)) + (SW'(hl_ff[k]) << (LO+1))
                        + SW'(ll_ff[k]);
         end
         mag6_ff  <= mag5_ff;
         neg6_ff  <= neg5_ff;
         last6_ff <= last5_ff;

         ss_ff  <= (2*RW)'(sq_ff[0]) + (2*RW)'(sq_ff[1]) + (2*RW)'(sq_ff[2]);
         sb7_ff <= {last6_ff, neg6_ff, mag6_ff[2], mag6_ff[1], mag6_ff[0]};
      end
   end

   tfn_sqrt_pipe #(
      .RW  (RW),
      .SBW (SBW)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (vld_ff[6]),
      .in_rad    (ss_ff),
      .in_sb     (sb7_ff),
      .out_valid (sq_vld),
      .out_root  (root),
      .out_sb    (sq_sb)
   );

   // a zero length is degenerate even when min_length is zero
   always_comb begin
      tag_in.last       = sq_sb[3*MW+3];
      tag_in.has_normal = (root != '0) && (CMPW'(root) >= CMPW'(min_length_ff));
      for (int k = 0; k < 3; k++) begin
         div_mag[k] = RW'(sq_sb[k*MW +: MW]);
      end
   end

   tfn_div_pipe #(
      .RW (RW),
      .QW (QW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sq_vld),
      .in_tag    (tag_in),
      .in_den    (root),
      .in_mag    (div_mag),
      .in_neg    (sq_sb[3*MW+2:3*MW]),
      .out_valid (div_vld),
      .out_tag   (div_tag),
      .out_q     (div_q),
      .out_neg   (div_neg)
   );

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (!div_tag.has_normal) begin
            rsp_data_in[k*NORM_WIDTH +: NORM_WIDTH] = '0;
         end else if (div_neg[k]) begin
            rsp_data_in[k*NORM_WIDTH +: NORM_WIDTH] = -NORM_WIDTH'(div_q[k]);
         end else begin
            rsp_data_in[k*NORM_WIDTH +: NORM_WIDTH] = NORM_WIDTH'(div_q[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= div_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= div_tag.has_normal;
         rsp_last_ff <= div_tag.last;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;
endmodule

FILE: design/tfn_sqrt_pipe.sv
// Pipelined integer square root, one root bit per stage, with a sideband word.
// No dependencies.
module tfn_sqrt_pipe #(
   parameter int RW  = 51,
   parameter int SBW = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  logic            in_valid,
   input  logic [2*RW-1:0] in_rad,
   input  logic [SBW-1:0]  in_sb,
   output logic            out_valid,
   output logic [RW-1:0]   out_root,
   output logic [SBW-1:0]  out_sb
);
   localparam int RMW = RW + 2;

   logic [RW-1:0]   vld_ff;
   logic [2*RW-1:0] rad_ff  [RW];
   logic [RMW-1:0]  rem_ff  [RW];
   logic [RW-1:0]   root_ff [RW];
   logic [SBW-1:0]  sb_ff   [RW];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[RW-2:0], in_valid};
      end
   end

   for (genvar i = 0; i < RW; i++) begin : g_stage
      logic [2*RW-1:0] rad_src;
      logic [RMW-1:0]  rem_src;
      logic [RW-1:0]   root_src;
      logic [SBW-1:0]  sb_src;
      logic [RMW-1:0]  cur;
      logic [RMW-1:0]  trial;
      logic [RMW-1:0]  diff;
      logic            take;

      if (i == 0) begin : g_first
         assign rad_src  = in_rad;
         assign rem_src  = '0;
         assign root_src = '0;
         assign sb_src   = in_sb;
      end else begin : g_next
         assign rad_src  = rad_ff[i-1];
         assign rem_src  = rem_ff[i-1];
         assign root_src = root_ff[i-1];
         assign sb_src   = sb_ff[i-1];
      end

      // bring down the next two radicand bits and try root*4+1
      assign cur   = {rem_src[RMW-3:0], rad_src[2*RW-1 -: 2]};
      assign trial = {root_src, 2'b01};
      assign take  = (cur >= trial);
      assign diff  = cur - trial;

      always_ff @(posedge clock) begin
         if (adv) begin
            rad_ff[i]  <= {rad_src[2*RW-3:0], 2'b00};
            rem_ff[i]  <= take ? diff : cur;
            root_ff[i] <= {root_src[RW-2:0], take};
            sb_ff[i]   <= sb_src;
         end
      end
   end

   assign out_valid = vld_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_sb    = sb_ff[RW-1];
endmodule

FILE: design/tfn_div_pipe.sv
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
// Depends on tfn_pkg for the tag type.
module tfn_div_pipe import tfn_pkg::*; #(
   parameter int RW = 51,
   parameter int QW = 31
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  tag_type             in_tag,
   input  logic [RW-1:0]       in_den,
   input  logic [2:0][RW-1:0]  in_mag,
   input  logic [2:0]          in_neg,
   output logic                out_valid,
   output tag_type             out_tag,
   output logic [2:0][QW-1:0]  out_q,
   output logic [2:0]          out_neg
);
   logic [QW-1:0]         vld_ff;
   logic [RW-1:0]         den_ff [QW];
   logic [2:0][RW-1:0]    rem_ff [QW];
   logic [2:0][QW-1:0]    q_ff   [QW];
   logic [2:0]            neg_ff [QW];
   tag_type               tag_ff [QW];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[QW-2:0], in_valid};
      end
   end

   for (genvar j = 0; j < QW; j++) begin : g_stage
      logic [RW-1:0]      den_src;
      logic [2:0][RW:0]   cur;
      logic [2:0][QW-1:0] q_src;
      logic [2:0]         neg_src;
      tag_type            tag_src;
      logic [2:0][RW:0]   diff;
      logic [2:0]         take;

      if (j == 0) begin : g_first
         // weight 2^(QW-1) compares the magnitude itself, never above the divisor
         for (genvar l = 0; l < 3; l++) begin : g_lane
            assign cur[l] = {1'b0, in_mag[l]};
         end
         assign den_src = in_den;
         assign q_src   = '0;
         assign neg_src = in_neg;
         assign tag_src = in_tag;
      end else begin : g_next
         for (genvar l = 0; l < 3; l++) begin : g_lane
            assign cur[l] = {rem_ff[j-1][l], 1'b0};
         end
         assign den_src = den_ff[j-1];
         assign q_src   = q_ff[j-1];
         assign neg_src = neg_ff[j-1];
         assign tag_src = tag_ff[j-1];
      end

      always_comb begin
         for (int l = 0; l < 3; l++) begin
            diff[l] = cur[l] - {1'b0, den_src};
            take[l] = (cur[l] >= {1'b0, den_src});
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            for (int l = 0; l < 3; l++) begin
               rem_ff[j][l] <= take[l] ? diff[l][RW-1:0] : cur[l][RW-1:0];
               q_ff[j][l]   <= {q_src[l][QW-2:0], take[l]};
            end
            den_ff[j] <= den_src;
            neg_ff[j] <= neg_src;
            tag_ff[j] <= tag_src;
         end
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_tag   = tag_ff[QW-1];
   assign out_q     = q_ff[QW-1];
   assign out_neg   = neg_ff[QW-1];
endmodule

FILE: design/tfn_checker.sv
// Port-level checks of the triangle face normal block, bound to the top level.
// Depends on tfn_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tfn_checker import tfn_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata,
   input logic             rsp_tuser
);
   `TFN_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_tvalid)
   `TFN_ASSERT(a_word_holds, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
   `TFN_ASSERT(a_ready_follows_out, clock, reset, req_tready == (!rsp_tvalid || rsp_tready))
   `TFN_ASSERT(a_degenerate_zero, clock, reset, rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
endmodule

bind triangle_face_normal_top tfn_checker u_tfn_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
